### sv/btffa_pkg.sv
// shared constants, command and status codes and sequencer states of the allocator
`timescale 1ns / 1ps
package btffa_pkg;

  localparam int DEF_ARENA_BYTES  = 65536;
  localparam int DEF_ALIGN_BYTES  = 8;
  localparam int DEF_HEADER_BYTES = 24;
  localparam int DEF_FOOTER_BYTES = 32;

  localparam int CMD_W    = 2;
  localparam int SIZE_W   = 17;
  localparam int ADDR_W   = 16;
  localparam int STAT_W   = 2;
  localparam int BYTES_W  = 17;
  localparam int LIVE_W   = 14;
  localparam int FAIL_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_STATS = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FAIL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_ROOT,
    S_IDLE,
    S_WALK,
    S_WCHK,
    S_PUT,
    S_FIX,
    S_F_HCHK,
    S_F_FCHK,
    S_F_NCHK,
    S_F_PREV,
    S_F_PCHK,
    S_RESP
  } state_t;

endpackage

### sv/boundary_tag_first_fit_allocator.sv
// top level: boundary-tag first-fit allocator with coalescing over tag memories
`timescale 1ns / 1ps
//
// channel | signals                                         | dir | moves
// --------+-------------------------------------------------+-----+--------------------------
// in      | in_valid/in_ready, command, size_bytes, address  | in  | one command word
// out     | out_valid/out_ready, status, payload_offset,     | out | one result word per
//         | held_bytes, high_water, biggest_hole,            |     | command word
//         | block_count, failed_allocs                       |     |
//
// one command word at a time; the head tag memory serves one registered read a cycle
// allocate and statistics walk the block chain from offset 0, block by block; an allocate
// that hits splits the block when the remainder is large enough, and a zero-size allocate
// fails without a walk
// free: check header, check footer, merge next, merge previous
// reset (rst) and an arena reset with no live blocks run a clearing pass through both
// tag memories and write the root block, with in_ready low
// a finished result waits in the output register while the next word is taken;
// the block only stalls before loading a new result into a still full output register
// ALIGN_BYTES is taken to be a power of two
module boundary_tag_first_fit_allocator #(
  parameter int ARENA_BYTES  = btffa_pkg::DEF_ARENA_BYTES,
  parameter int ALIGN_BYTES  = btffa_pkg::DEF_ALIGN_BYTES,
  parameter int HEADER_BYTES = btffa_pkg::DEF_HEADER_BYTES,
  parameter int FOOTER_BYTES = btffa_pkg::DEF_FOOTER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [btffa_pkg::CMD_W-1:0]   command,
  input  logic [btffa_pkg::SIZE_W-1:0]  size_bytes,
  input  logic [btffa_pkg::ADDR_W-1:0]  address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btffa_pkg::STAT_W-1:0]  status,
  output logic [btffa_pkg::ADDR_W-1:0]  payload_offset,
  output logic [btffa_pkg::BYTES_W-1:0] held_bytes,
  output logic [btffa_pkg::BYTES_W-1:0] high_water,
  output logic [btffa_pkg::BYTES_W-1:0] biggest_hole,
  output logic [btffa_pkg::LIVE_W-1:0]  block_count,
  output logic [btffa_pkg::FAIL_W-1:0]  failed_allocs
);

  // byte sizes, offsets and tag memory geometry
  localparam int AW     = $clog2(ARENA_BYTES + 1);
  localparam int ALG    = $clog2(ALIGN_BYTES);
  localparam int HDR_SZ = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int FTR_SZ = (FOOTER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
  localparam int MIN_BLK = HDR_SZ + FTR_SZ + ALIGN_BYTES;
  localparam int GRAN   = ARENA_BYTES / ALIGN_BYTES + 1;
  localparam int IW     = $clog2(GRAN);
  localparam int RW     = (AW > btffa_pkg::SIZE_W ? AW : btffa_pkg::SIZE_W) + 2;
  localparam int CW     = (AW > btffa_pkg::ADDR_W ? AW : btffa_pkg::ADDR_W) + 1;

  localparam logic [AW:0]   END_X  = (AW+1)'(ARENA_BYTES);
  localparam logic [AW:0]   MIN_X  = (AW+1)'(MIN_BLK);
  localparam logic [AW-1:0] MIN_S  = AW'(MIN_BLK);
  localparam logic [AW-1:0] END_S  = AW'(ARENA_BYTES);
  localparam logic [IW-1:0] LAST_I = IW'(GRAN - 1);
  localparam logic [btffa_pkg::LIVE_W-1:0] LIVE_MAX = '1;
  localparam logic [btffa_pkg::FAIL_W-1:0] FAIL_MAX = '1;

  typedef struct packed {
    logic          start;
    logic          free;
    logic [AW-1:0] size;
    logic [AW-1:0] prev;
  } head_t;

  typedef struct packed {
    logic          valid;
    logic          free;
    logic [AW-1:0] size;
  } foot_t;

  // granule index of a byte offset, clamped to the last entry
  function automatic logic [IW-1:0] gi(input logic [AW:0] x);
    logic [AW:0] g;
    g = x >> ALG;
    if (g < (AW+1)'(GRAN)) begin
      return g[IW-1:0];
    end
    return LAST_I;
  endfunction

  // footer entry of a block that ends at byte offset x
  function automatic logic [IW-1:0] fi(input logic [AW:0] x);
    logic [IW-1:0] g;
    g = gi(x);
    if (g == '0) begin
      return '0;
    end
    return g - IW'(1);
  endfunction

  // tag memories, one write and one registered read a cycle each
  head_t head_mem [GRAN];
  foot_t foot_mem [GRAN];
  head_t head_q;
  foot_t foot_q;

  logic          h_we, h_re, f_we, f_re;
  logic [IW-1:0] h_wa, h_ra, f_wa, f_ra;
  head_t         h_wd;
  foot_t         f_wd;

  always_ff @(posedge clk) begin
    if (h_we) begin
      head_mem[h_wa] <= h_wd;
    end
    if (h_re) begin
      head_q <= head_mem[h_ra];
    end
    if (f_we) begin
      foot_mem[f_wa] <= f_wd;
    end
    if (f_re) begin
      foot_q <= foot_mem[f_ra];
    end
  end

  // control and working registers
  btffa_pkg::state_t state, state_next, ret, ret_next;
  btffa_pkg::cmd_t   cmd, cmd_next;
  logic              boot, boot_next;
  logic [IW-1:0]     clr_cnt, clr_cnt_next;
  logic [AW-1:0]     off, off_next;     // current block offset
  logic [AW-1:0]     acc, acc_next;     // size of the block being written
  head_t             blk, blk_next;     // header of the block under work
  logic [RW-1:0]     req, req_next;     // aligned request with overhead
  logic [AW-1:0]     best, best_next;   // largest free block seen on a walk
  logic [btffa_pkg::ADDR_W-1:0] pay, pay_next;
  btffa_pkg::status_t st, st_next;

  // arena counters
  logic [AW-1:0]                 used, used_next;
  logic [AW-1:0]                 peak, peak_next;
  logic [btffa_pkg::LIVE_W-1:0]  live, live_next;
  logic [btffa_pkg::FAIL_W-1:0]  fails, fails_next;

  // output register
  logic                          ov, ov_next;
  btffa_pkg::status_t            o_st, o_st_next;
  logic [btffa_pkg::ADDR_W-1:0]  o_pay, o_pay_next;
  logic [btffa_pkg::BYTES_W-1:0] o_used, o_used_next;
  logic [btffa_pkg::BYTES_W-1:0] o_peak, o_peak_next;
  logic [btffa_pkg::BYTES_W-1:0] o_big, o_big_next;
  logic [btffa_pkg::LIVE_W-1:0]  o_live, o_live_next;
  logic [btffa_pkg::FAIL_W-1:0]  o_fail, o_fail_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= btffa_pkg::S_CLEAR;
      ret     <= btffa_pkg::S_RESP;
      boot    <= 1'b1;
      clr_cnt <= '0;
      used    <= '0;
      peak    <= '0;
      live    <= '0;
      fails   <= '0;
      ov      <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      boot    <= boot_next;
      clr_cnt <= clr_cnt_next;
      used    <= used_next;
      peak    <= peak_next;
      live    <= live_next;
      fails   <= fails_next;
      ov      <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    off    <= off_next;
    acc    <= acc_next;
    blk    <= blk_next;
    req    <= req_next;
    best   <= best_next;
    pay    <= pay_next;
    st     <= st_next;
    o_st   <= o_st_next;
    o_pay  <= o_pay_next;
    o_used <= o_used_next;
    o_peak <= o_peak_next;
    o_big  <= o_big_next;
    o_live <= o_live_next;
    o_fail <= o_fail_next;
  end

  always_comb begin
    logic [AW:0]    off_x, end_x, nx_x, walk_x, sum_x;
    logic [CW-1:0]  addr_x, pv_x;
    logic [RW-1:0]  pay_r;
    logic [AW-1:0]  rem, taken, new_used;
    logic           out_free;

    state_next   = state;
    ret_next     = ret;
    boot_next    = boot;
    clr_cnt_next = clr_cnt;
    cmd_next     = cmd;
    off_next     = off;
    acc_next     = acc;
    blk_next     = blk;
    req_next     = req;
    best_next    = best;
    pay_next     = pay;
    st_next      = st;
    used_next    = used;
    peak_next    = peak;
    live_next    = live;
    fails_next   = fails;
    ov_next      = ov;
    o_st_next    = o_st;
    o_pay_next   = o_pay;
    o_used_next  = o_used;
    o_peak_next  = o_peak;
    o_big_next   = o_big;
    o_live_next  = o_live;
    o_fail_next  = o_fail;

    h_we = 1'b0;
    h_wa = '0;
    h_wd = '0;
    h_re = 1'b0;
    h_ra = '0;
    f_we = 1'b0;
    f_wa = '0;
    f_wd = '0;
    f_re = 1'b0;
    f_ra = '0;

    in_ready = 1'b0;
    out_free = !ov || out_ready;
    if (ov && out_ready) begin
      ov_next = 1'b0;
    end

    off_x    = {1'b0, off};
    end_x    = off_x + {1'b0, acc};
    nx_x     = off_x + {1'b0, head_q.size};
    walk_x   = off_x + MIN_X;
    sum_x    = {1'b0, head_q.size} + {1'b0, acc};
    addr_x   = CW'(address);
    pv_x     = CW'(off) - CW'(blk.prev);
    pay_r    = (RW'(size_bytes) + RW'(ALIGN_BYTES - 1)) & ~RW'(ALIGN_BYTES - 1);
    rem      = head_q.size - req[AW-1:0];
    taken    = (rem >= MIN_S) ? req[AW-1:0] : head_q.size;
    new_used = used + taken;

    case (state)
      // zero both tag memories, one entry a cycle
      btffa_pkg::S_CLEAR: begin
        h_we = 1'b1;
        h_wa = clr_cnt;
        f_we = 1'b1;
        f_wa = clr_cnt;
        if (clr_cnt == LAST_I) begin
          state_next = btffa_pkg::S_ROOT;
        end else begin
          clr_cnt_next = clr_cnt + IW'(1);
        end
      end

      // one free block spanning the arena
      btffa_pkg::S_ROOT: begin
        h_we = 1'b1;
        h_wa = '0;
        h_wd = '{start: 1'b1, free: 1'b1, size: END_S, prev: '0};
        f_we = 1'b1;
        f_wa = fi(END_X);
        f_wd = '{valid: 1'b1, free: 1'b1, size: END_S};
        used_next  = '0;
        peak_next  = '0;
        live_next  = '0;
        fails_next = '0;
        boot_next  = 1'b0;
        state_next = boot ? btffa_pkg::S_IDLE : btffa_pkg::S_RESP;
      end

      btffa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_next  = btffa_pkg::cmd_t'(command);
          off_next  = '0;
          best_next = '0;
          pay_next  = '0;
          st_next   = btffa_pkg::ST_OK;
          req_next  = pay_r + RW'(HDR_SZ + FTR_SZ);
          case (btffa_pkg::cmd_t'(command))
            btffa_pkg::CMD_ALLOC: begin
              if (size_bytes == '0) begin
                st_next    = btffa_pkg::ST_FAIL;
                fails_next = (fails != FAIL_MAX) ? fails + 1'b1 : fails;
                state_next = btffa_pkg::S_RESP;
              end else begin
                state_next = btffa_pkg::S_WALK;
              end
            end
            btffa_pkg::CMD_FREE: begin
              off_next = AW'(addr_x - CW'(HDR_SZ));
              if (addr_x < CW'(HDR_SZ) || addr_x >= CW'(ARENA_BYTES) ||
                  ((addr_x - CW'(HDR_SZ)) & CW'(ALIGN_BYTES - 1)) != '0) begin
                st_next    = btffa_pkg::ST_INVALID;
                state_next = btffa_pkg::S_RESP;
              end else begin
                h_re       = 1'b1;
                h_ra       = gi((AW+1)'(addr_x - CW'(HDR_SZ)));
                state_next = btffa_pkg::S_F_HCHK;
              end
            end
            btffa_pkg::CMD_RESET: begin
              if (live != '0) begin
                st_next    = btffa_pkg::ST_BUSY;
                state_next = btffa_pkg::S_RESP;
              end else begin
                clr_cnt_next = '0;
                state_next   = btffa_pkg::S_CLEAR;
              end
            end
            default: begin
              state_next = btffa_pkg::S_WALK;
            end
          endcase
        end
      end

      // chain walk shared by first-fit and the statistics query
      btffa_pkg::S_WALK: begin
        if (walk_x > END_X) begin
          if (cmd == btffa_pkg::CMD_ALLOC) begin
            st_next    = btffa_pkg::ST_FAIL;
            fails_next = (fails != FAIL_MAX) ? fails + 1'b1 : fails;
          end
          state_next = btffa_pkg::S_RESP;
        end else begin
          h_re       = 1'b1;
          h_ra       = gi(off_x);
          state_next = btffa_pkg::S_WCHK;
        end
      end

      btffa_pkg::S_WCHK: begin
        if (!head_q.start || head_q.size < MIN_S) begin
          // broken chain ends the walk
          if (cmd == btffa_pkg::CMD_ALLOC) begin
            st_next    = btffa_pkg::ST_FAIL;
            fails_next = (fails != FAIL_MAX) ? fails + 1'b1 : fails;
          end
          state_next = btffa_pkg::S_RESP;
        end else if (cmd == btffa_pkg::CMD_ALLOC && head_q.free &&
                     RW'(head_q.size) >= req) begin
          used_next = new_used;
          if (new_used > peak) begin
            peak_next = new_used;
          end
          if (live < LIVE_MAX) begin
            live_next = live + 1'b1;
          end
          pay_next = btffa_pkg::ADDR_W'(off_x + (AW+1)'(HDR_SZ));
          h_we = 1'b1;
          h_wa = gi(off_x);
          h_wd = '{start: 1'b1, free: 1'b0, size: taken, prev: head_q.prev};
          f_we = 1'b1;
          f_wa = fi(off_x + {1'b0, taken});
          f_wd = '{valid: 1'b1, free: 1'b0, size: taken};
          if (rem >= MIN_S) begin
            // split: the remainder becomes a free block after the taken one
            off_next      = off + req[AW-1:0];
            acc_next      = rem;
            blk_next      = head_q;
            blk_next.prev = req[AW-1:0];
            ret_next      = btffa_pkg::S_RESP;
            state_next    = btffa_pkg::S_PUT;
          end else begin
            state_next = btffa_pkg::S_RESP;
          end
        end else begin
          // largest free block is only reported on a statistics query
          if (cmd == btffa_pkg::CMD_STATS && head_q.free && head_q.size > best) begin
            best_next = head_q.size;
          end
          off_next   = AW'(nx_x);
          state_next = btffa_pkg::S_WALK;
        end
      end

      // write a free block at off of size acc, then look at its successor
      btffa_pkg::S_PUT: begin
        h_we = 1'b1;
        h_wa = gi(off_x);
        h_wd = '{start: 1'b1, free: 1'b1, size: acc, prev: blk.prev};
        f_we = 1'b1;
        f_wa = fi(end_x);
        f_wd = '{valid: 1'b1, free: 1'b1, size: acc};
        if (end_x < END_X) begin
          h_re       = 1'b1;
          h_ra       = gi(end_x);
          state_next = btffa_pkg::S_FIX;
        end else begin
          state_next = ret;
        end
      end

      // successor's back link
      btffa_pkg::S_FIX: begin
        if (head_q.start) begin
          h_we      = 1'b1;
          h_wa      = gi(end_x);
          h_wd      = head_q;
          h_wd.prev = acc;
        end
        state_next = ret;
      end

      btffa_pkg::S_F_HCHK: begin
        blk_next = head_q;
        acc_next = head_q.size;
        if (!head_q.start || head_q.free || head_q.size < MIN_S ||
            {1'b0, head_q.size} > END_X - off_x) begin
          st_next    = btffa_pkg::ST_INVALID;
          state_next = btffa_pkg::S_RESP;
        end else begin
          f_re       = 1'b1;
          f_ra       = fi(nx_x);
          state_next = btffa_pkg::S_F_FCHK;
        end
      end

      btffa_pkg::S_F_FCHK: begin
        if (!foot_q.valid || foot_q.size != acc || foot_q.free) begin
          st_next    = btffa_pkg::ST_INVALID;
          state_next = btffa_pkg::S_RESP;
        end else begin
          used_next = (used >= acc) ? used - acc : '0;
          if (live != '0) begin
            live_next = live - 1'b1;
          end
          h_we = 1'b1;
          h_wa = gi(off_x);
          h_wd = '{start: 1'b1, free: 1'b1, size: acc, prev: blk.prev};
          f_we = 1'b1;
          f_wa = fi(end_x);
          f_wd = '{valid: 1'b1, free: 1'b1, size: acc};
          if (end_x < END_X) begin
            h_re       = 1'b1;
            h_ra       = gi(end_x);
            state_next = btffa_pkg::S_F_NCHK;
          end else begin
            state_next = btffa_pkg::S_F_PREV;
          end
        end
      end

      // merge with a free following block
      btffa_pkg::S_F_NCHK: begin
        if (head_q.start && head_q.free) begin
          h_we       = 1'b1;
          h_wa       = gi(end_x);
          h_wd       = head_q;
          h_wd.start = 1'b0;
          acc_next   = AW'(sum_x);
          ret_next   = btffa_pkg::S_F_PREV;
          state_next = btffa_pkg::S_PUT;
        end else begin
          state_next = btffa_pkg::S_F_PREV;
        end
      end

      btffa_pkg::S_F_PREV: begin
        if (blk.prev != '0 && blk.prev <= off) begin
          h_re       = 1'b1;
          h_ra       = gi((AW+1)'(pv_x));
          state_next = btffa_pkg::S_F_PCHK;
        end else begin
          state_next = btffa_pkg::S_RESP;
        end
      end

      // merge into a free preceding block
      btffa_pkg::S_F_PCHK: begin
        if (head_q.start && head_q.free) begin
          h_we          = 1'b1;
          h_wa          = gi(off_x);
          h_wd          = '{start: 1'b0, free: 1'b1, size: acc, prev: blk.prev};
          off_next      = AW'(pv_x);
          acc_next      = AW'(sum_x);
          blk_next.prev = head_q.prev;
          ret_next      = btffa_pkg::S_RESP;
          state_next    = btffa_pkg::S_PUT;
        end else begin
          state_next = btffa_pkg::S_RESP;
        end
      end

      btffa_pkg::S_RESP: begin
        if (out_free) begin
          ov_next     = 1'b1;
          o_st_next   = st;
          o_pay_next  = pay;
          o_used_next = btffa_pkg::BYTES_W'(used);
          o_peak_next = btffa_pkg::BYTES_W'(peak);
          o_big_next  = btffa_pkg::BYTES_W'(best);
          o_live_next = live;
          o_fail_next = fails;
          state_next  = btffa_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = btffa_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid      = ov;
  assign status         = o_st;
  assign payload_offset = o_pay;
  assign held_bytes     = o_used;
  assign high_water     = o_peak;
  assign biggest_hole   = o_big;
  assign block_count    = o_live;
  assign failed_allocs  = o_fail;

endmodule

### sv/btffa_checker.sv
// port-level checks of the allocator and their binding to the top level
`timescale 1ns / 1ps
module btffa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [btffa_pkg::CMD_W-1:0]   command,
  input logic [btffa_pkg::SIZE_W-1:0]  size_bytes,
  input logic [btffa_pkg::ADDR_W-1:0]  address,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [btffa_pkg::STAT_W-1:0]  status,
  input logic [btffa_pkg::ADDR_W-1:0]  payload_offset,
  input logic [btffa_pkg::BYTES_W-1:0] held_bytes,
  input logic [btffa_pkg::BYTES_W-1:0] high_water,
  input logic [btffa_pkg::BYTES_W-1:0] biggest_hole,
  input logic [btffa_pkg::LIVE_W-1:0]  block_count,
  input logic [btffa_pkg::FAIL_W-1:0]  failed_allocs
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_offset))
    else $error("result word changed while stalled");

  // offset only on success
  a_pay_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != btffa_pkg::ST_OK |-> payload_offset == '0)
    else $error("payload offset on a failed command");

  // busy reset needs live blocks
  a_busy_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == btffa_pkg::ST_BUSY |-> block_count != '0)
    else $error("reset refused with no live blocks");

  a_empty_used: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_count == '0 |-> held_bytes == '0)
    else $error("bytes in use with no live blocks");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> held_bytes <= high_water)
    else $error("usage above peak");

endmodule

bind boundary_tag_first_fit_allocator btffa_checker u_btffa_checker (.*);

### tb/tb_boundary_tag_first_fit_allocator.sv
// self-checking testbench for the boundary-tag first-fit allocator
`timescale 1ns / 1ps
module tb_boundary_tag_first_fit_allocator;

  // arena geometry at the default parameters
  localparam int unsigned ARENA = btffa_pkg::DEF_ARENA_BYTES;
  localparam int unsigned ALIGN = btffa_pkg::DEF_ALIGN_BYTES;
  localparam int unsigned HDR   = (btffa_pkg::DEF_HEADER_BYTES + ALIGN - 1) / ALIGN * ALIGN;
  localparam int unsigned FTR   = (btffa_pkg::DEF_FOOTER_BYTES + ALIGN - 1) / ALIGN * ALIGN;
  localparam int unsigned MINB  = HDR + FTR + ALIGN;
  localparam int unsigned GRAN  = ARENA / ALIGN + 1;
  localparam int unsigned LIVE_MAX = 16383;
  localparam int N_RANDOM  = 1925;
  localparam int PHASE_LEN = 150;
  // covers the clearing pass plus the longest walk with stalls, several times over
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    btffa_pkg::status_t            st;
    logic [btffa_pkg::ADDR_W-1:0]  off;
    logic [btffa_pkg::BYTES_W-1:0] used;
    logic [btffa_pkg::BYTES_W-1:0] peak;
    logic [btffa_pkg::BYTES_W-1:0] lf;
    logic [btffa_pkg::LIVE_W-1:0]  live;
    logic [btffa_pkg::FAIL_W-1:0]  fails;
  } result_word_t;

  typedef struct {
    btffa_pkg::cmd_t    cmd;
    int unsigned        size;
    int unsigned        addr;
    bit                 typed;
    btffa_pkg::status_t st;
    int unsigned        off;
    int unsigned        lf;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [btffa_pkg::CMD_W-1:0]  command = '0;
  logic [btffa_pkg::SIZE_W-1:0] size_bytes = '0;
  logic [btffa_pkg::ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [btffa_pkg::STAT_W-1:0]  status;
  logic [btffa_pkg::ADDR_W-1:0]  payload_offset;
  logic [btffa_pkg::BYTES_W-1:0] held_bytes, high_water, biggest_hole;
  logic [btffa_pkg::LIVE_W-1:0]  block_count;
  logic [btffa_pkg::FAIL_W-1:0]  failed_allocs;

  boundary_tag_first_fit_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .size_bytes(size_bytes), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .payload_offset(payload_offset),
    .held_bytes(held_bytes), .high_water(high_water), .biggest_hole(biggest_hole),
    .block_count(block_count), .failed_allocs(failed_allocs)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the tag memories and counters
  bit          hd_start [GRAN];
  bit          hd_free  [GRAN];
  int unsigned hd_size  [GRAN];
  int unsigned hd_prev  [GRAN];
  bit          ft_valid [GRAN];
  bit          ft_free  [GRAN];
  int unsigned ft_size  [GRAN];
  int unsigned used_cnt, peak_cnt, live_cnt, fail_cnt;

  int unsigned  live_addrs[$];  // payload offsets currently allocated
  result_word_t pending_results[$];
  stim_row_t    dir_rows[$];

  int  errors = 0;
  int  words_sent = 0;
  bit  stim_done = 1'b0;
  bit  calm = 1'b0;
  int  phase_words = 0;
  int  idle_cycles = 0;

  function automatic int unsigned gidx(int unsigned o);
    int unsigned g;
    g = o / ALIGN;
    return (g < GRAN) ? g : GRAN - 1;
  endfunction

  function automatic void put_block(int unsigned o, int unsigned sz, int unsigned pv, bit fr);
    int unsigned hi, fi;
    hi = gidx(o);
    fi = gidx(o + sz);
    hd_start[hi] = 1'b1;
    hd_free[hi]  = fr;
    hd_size[hi]  = sz;
    hd_prev[hi]  = pv;
    if (fi > 0) fi--;
    ft_valid[fi] = 1'b1;
    ft_free[fi]  = fr;
    ft_size[fi]  = sz;
  endfunction

  function automatic void link_next(int unsigned o);
    int unsigned nx;
    nx = o + hd_size[gidx(o)];
    if (nx < ARENA && hd_start[gidx(nx)]) hd_prev[gidx(nx)] = hd_size[gidx(o)];
  endfunction

  function automatic void arena_init();
    for (int i = 0; i < GRAN; i++) begin
      hd_start[i] = 0; hd_free[i] = 0; hd_size[i] = 0; hd_prev[i] = 0;
      ft_valid[i] = 0; ft_free[i] = 0; ft_size[i] = 0;
    end
    put_block(0, ARENA, 0, 1'b1);
    used_cnt = 0; peak_cnt = 0; live_cnt = 0; fail_cnt = 0;
    live_addrs.delete();
  endfunction

  function automatic void bump_fail();
    if (fail_cnt != 32'hFFFF_FFFF) fail_cnt++;
  endfunction

  // first-fit carve; returns the status code, offset through po
  function automatic btffa_pkg::status_t carve(int unsigned sz, output int unsigned po);
    int unsigned pay, req, o, rem, taken, hi;
    po = 0;
    if (sz == 0) begin
      bump_fail();
      return btffa_pkg::ST_FAIL;
    end
    pay = (sz + ALIGN - 1) / ALIGN * ALIGN;
    req = pay + HDR + FTR;
    o = 0;
    while (o + MINB <= ARENA) begin
      hi = gidx(o);
      if (!hd_start[hi] || hd_size[hi] < MINB) break;
      if (hd_free[hi] && hd_size[hi] >= req) begin
        rem = hd_size[hi] - req;
        taken = hd_size[hi];
        if (rem >= MINB) begin
          put_block(o + req, rem, req, 1'b1);
          put_block(o, req, hd_prev[hi], 1'b0);
          link_next(o + req);
          taken = req;
        end else begin
          put_block(o, hd_size[hi], hd_prev[hi], 1'b0);
        end
        used_cnt += taken;
        if (used_cnt > peak_cnt) peak_cnt = used_cnt;
        if (live_cnt < LIVE_MAX) live_cnt++;
        po = o + HDR;
        live_addrs.push_back(po);
        return btffa_pkg::ST_OK;
      end
      o += hd_size[hi];
    end
    bump_fail();
    return btffa_pkg::ST_FAIL;
  endfunction

  // check and release a block, merging the following then the preceding neighbour
  function automatic btffa_pkg::status_t give_back(int unsigned a);
    int unsigned o, sz, nx, pv, hi, fi, h_sz, h_pv;
    bit h_st, h_fr;
    if (a < HDR || a >= ARENA) return btffa_pkg::ST_INVALID;
    o = a - HDR;
    if (o % ALIGN != 0) return btffa_pkg::ST_INVALID;
    hi = gidx(o);
    h_st = hd_start[hi]; h_fr = hd_free[hi]; h_sz = hd_size[hi]; h_pv = hd_prev[hi];
    if (!h_st || h_fr || h_sz < MINB || h_sz > ARENA - o) return btffa_pkg::ST_INVALID;
    fi = gidx(o + h_sz) - 1;
    if (!ft_valid[fi] || ft_size[fi] != h_sz || ft_free[fi] != h_fr)
      return btffa_pkg::ST_INVALID;
    sz = h_sz;
    used_cnt = (used_cnt >= sz) ? used_cnt - sz : 0;
    if (live_cnt != 0) live_cnt--;
    put_block(o, sz, h_pv, 1'b1);
    nx = o + sz;
    if (nx < ARENA && hd_start[gidx(nx)] && hd_free[gidx(nx)]) begin
      sz += hd_size[gidx(nx)];
      hd_start[gidx(nx)] = 1'b0;
      put_block(o, sz, h_pv, 1'b1);
      link_next(o);
    end
    if (h_pv != 0 && h_pv <= o) begin
      pv = o - h_pv;
      if (hd_start[gidx(pv)] && hd_free[gidx(pv)]) begin
        hd_start[hi] = 1'b0;
        put_block(pv, hd_size[gidx(pv)] + sz, hd_prev[gidx(pv)], 1'b1);
        link_next(pv);
      end
    end
    foreach (live_addrs[i]) if (live_addrs[i] == a) begin
      live_addrs.delete(i);
      break;
    end
    return btffa_pkg::ST_OK;
  endfunction

  function automatic int unsigned widest_hole();
    int unsigned o, best, hi;
    o = 0; best = 0;
    while (o + MINB <= ARENA) begin
      hi = gidx(o);
      if (!hd_start[hi] || hd_size[hi] < MINB) break;
      if (hd_free[hi] && hd_size[hi] > best) best = hd_size[hi];
      o += hd_size[hi];
    end
    return best;
  endfunction

  // advance the shadow state by one accepted command word
  function automatic result_word_t apply_command(btffa_pkg::cmd_t c, int unsigned sz,
                                                 int unsigned a);
    result_word_t r;
    int unsigned po, lf;
    po = 0; lf = 0;
    r.st = btffa_pkg::ST_OK;
    case (c)
      btffa_pkg::CMD_ALLOC: r.st = carve(sz, po);
      btffa_pkg::CMD_FREE:  r.st = give_back(a);
      btffa_pkg::CMD_RESET: begin
        if (live_cnt != 0) r.st = btffa_pkg::ST_BUSY;
        else arena_init();
      end
      default:   lf = widest_hole();
    endcase
    r.off = po[btffa_pkg::ADDR_W-1:0];
    r.used = used_cnt[btffa_pkg::BYTES_W-1:0];
    r.peak = peak_cnt[btffa_pkg::BYTES_W-1:0];
    r.lf = lf[btffa_pkg::BYTES_W-1:0];
    r.live = live_cnt[btffa_pkg::LIVE_W-1:0];
    r.fails = fail_cnt;
    return r;
  endfunction

  function automatic void add_row(btffa_pkg::cmd_t c, int unsigned sz, int unsigned a,
                                  bit typed, btffa_pkg::status_t st, int unsigned off,
                                  int unsigned lf);
    stim_row_t r;
    r.cmd = c; r.size = sz; r.addr = a; r.typed = typed; r.st = st; r.off = off; r.lf = lf;
    dir_rows.push_back(r);
  endfunction

  // random command word; drifts toward draining the arena at the end of each phase
  task automatic pick_random(output btffa_pkg::cmd_t c, output int unsigned sz,
                             output int unsigned a);
    int unsigned r;
    c = btffa_pkg::CMD_STATS; sz = $urandom; a = $urandom;
    sz = sz & 17'h1FFFF; a = a & 16'hFFFF;
    if (phase_words >= PHASE_LEN) begin
      if (live_addrs.size() != 0) begin
        c = btffa_pkg::CMD_FREE;
        a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
      end else begin
        c = btffa_pkg::CMD_RESET;
        phase_words = 0;
      end
      return;
    end
    phase_words++;
    r = $urandom_range(0, 99);
    if (r < 42 || (r < 72 && live_addrs.size() == 0)) begin
      c = btffa_pkg::CMD_ALLOC;
      r = $urandom_range(0, 99);
      if (r < 2)       sz = 0;
      else if (r < 70) sz = $urandom_range(1, 256);
      else if (r < 90) sz = $urandom_range(1, 4096);
      else if (r < 97) sz = $urandom_range(1, 20000);
    end else if (r < 72) begin
      c = btffa_pkg::CMD_FREE;
      a = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    end else if (r < 82) begin
      c = btffa_pkg::CMD_FREE;  // noise address, almost always rejected
    end else if (r < 86 && live_addrs.size() != 0) begin
      c = btffa_pkg::CMD_FREE;  // near a real block: misaligned or inside it
      a = (live_addrs[$urandom_range(0, live_addrs.size() - 1)] + $urandom_range(1, 80))
          & 16'hFFFF;
    end else if (r < 96) begin
      c = btffa_pkg::CMD_STATS;
    end else begin
      c = btffa_pkg::CMD_RESET; // busy unless the arena is empty
    end
  endtask

  initial begin
    arena_init();
    // after reset, extremes, bad frees, busy reset, split and coalescing
    add_row(btffa_pkg::CMD_STATS, 0,      0,     1, btffa_pkg::ST_OK,      0,  ARENA);
    add_row(btffa_pkg::CMD_ALLOC, 0,      0,     1, btffa_pkg::ST_FAIL,    0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 1,      0,     1, btffa_pkg::ST_OK,      24, 0);
    add_row(btffa_pkg::CMD_ALLOC, 65536,  0,     1, btffa_pkg::ST_FAIL,    0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      0,     1, btffa_pkg::ST_INVALID, 0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      24,    1, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      24,    1, btffa_pkg::ST_INVALID, 0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      25,    1, btffa_pkg::ST_INVALID, 0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      65535, 1, btffa_pkg::ST_INVALID, 0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 65480,  0,     1, btffa_pkg::ST_OK,      24, 0);
    add_row(btffa_pkg::CMD_STATS, 0,      0,     1, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 1,      0,     1, btffa_pkg::ST_FAIL,    0,  0);
    add_row(btffa_pkg::CMD_RESET, 0,      0,     1, btffa_pkg::ST_BUSY,    0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      24,    1, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_RESET, 0,      0,     1, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 131071, 65535, 1, btffa_pkg::ST_FAIL,    0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 8,      0,     0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 8,      0,     0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 8,      0,     0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      88,    0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      24,    0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_FREE,  0,      152,   0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_STATS, 0,      0,     1, btffa_pkg::ST_OK,      0,  ARENA);
    add_row(btffa_pkg::CMD_ALLOC, 65416,  0,     0, btffa_pkg::ST_OK,      0,  0);
    add_row(btffa_pkg::CMD_ALLOC, 1,      0,     0, btffa_pkg::ST_OK,      0,  0);
  end

  // reset once, then hand over to the driver
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // command side: predict on acceptance, then drive the next word or idle
  initial begin
    btffa_pkg::cmd_t c;
    int unsigned     sz, a, ridx;
    bit              accepted;
    result_word_t    exp_word;
    ridx = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      accepted = in_valid && in_ready;
      if (accepted) begin
        exp_word = apply_command(btffa_pkg::cmd_t'(command), size_bytes, address);
        if (ridx <= dir_rows.size() && words_sent < dir_rows.size()
            && dir_rows[words_sent].typed) begin
          exp_word.st  = dir_rows[words_sent].st;
          exp_word.off = dir_rows[words_sent].off[btffa_pkg::ADDR_W-1:0];
          exp_word.lf  = dir_rows[words_sent].lf[btffa_pkg::BYTES_W-1:0];
        end
        pending_results.push_back(exp_word);
        words_sent++;
      end
      calm = (words_sent >= 700 && words_sent < 1000);
      if (accepted || !in_valid) begin
        if (ridx >= dir_rows.size() + N_RANDOM) begin
          in_valid <= 1'b0;
          stim_done = 1'b1;
        end else if (!calm && $urandom_range(0, 99) < 34) begin
          in_valid <= 1'b0;
        end else begin
          if (ridx < dir_rows.size()) begin
            c = dir_rows[ridx].cmd; sz = dir_rows[ridx].size; a = dir_rows[ridx].addr;
          end else begin
            pick_random(c, sz, a);
          end
          ridx++;
          command    <= c;
          size_bytes <= sz[btffa_pkg::SIZE_W-1:0];
          address    <= a[btffa_pkg::ADDR_W-1:0];
          in_valid   <= 1'b1;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned e, longint unsigned act);
    if (e != act) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, e, act);
    end
  endfunction

  // result side: random back-pressure, compare with the oldest expectation
  always @(posedge clk) begin
    result_word_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, status %0d", $realtime, status);
        end else begin
          e = pending_results.pop_front();
          check_field("status",         e.st,    status);
          check_field("payload_offset", e.off,   payload_offset);
          check_field("held_bytes",     e.used,  held_bytes);
          check_field("high_water",     e.peak,  high_water);
          check_field("biggest_hole",   e.lf,    biggest_hole);
          check_field("block_count",    e.live,  block_count);
          check_field("failed_allocs",  e.fails, failed_allocs);
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end
  end

  // watchdog on cycles in which neither channel moves a word
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("boundary_tag_first_fit_allocator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    @(negedge rst);
    wait (stim_done && pending_results.size() == 0);
    // let a late stray word show up before the verdict
    repeat (3000) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("boundary_tag_first_fit_allocator regression: pass");
    end else begin
      $display("boundary_tag_first_fit_allocator regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
sv/btffa_pkg.sv
sv/boundary_tag_first_fit_allocator.sv
sv/btffa_checker.sv
tb/tb_boundary_tag_first_fit_allocator.sv
